// ===== design/stp_pkg.sv =====
// shared types, constants and helpers of the string to integer parser
package stp_pkg;

    // character codes
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7a;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5a;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_VT    = 8'h0b;
    localparam logic [7:0] CH_FF    = 8'h0c;
    localparam logic [7:0] CH_CR    = 8'h0d;

    // digit values and bases
    localparam logic [5:0] NO_DIGIT   = 6'd36;
    localparam logic [5:0] BASE_AUTO  = 6'd0;
    localparam logic [5:0] BASE_ONE   = 6'd1;
    localparam logic [5:0] BASE_OCT   = 6'd8;
    localparam logic [5:0] BASE_DEC   = 6'd10;
    localparam logic [5:0] BASE_HEX   = 6'd16;
    localparam logic [5:0] BASE_MAX   = 6'd36;
    localparam logic [5:0] BASE_RESET = BASE_DEC;

    // limits
    localparam int unsigned DEF_MAX_LENGTH = 4095;
    localparam int unsigned OFF_MAX        = 4095;
    localparam int unsigned QUEUE_DEPTH    = 2;

    // register map
    localparam logic REG_NUMBER_BASE = 1'b0;

    // parser phases
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_SPACE  = 3'd1,
        PH_SIGN   = 3'd2,
        PH_ZERO   = 3'd3,
        PH_XPFX   = 3'd4,
        PH_DIGITS = 3'd5
    } phase_t;

    // input beat
    typedef struct packed {
        logic [7:0] char_code;
        logic       string_start;
    } in_beat_t;

    // result beat
    typedef struct packed {
        logic signed [63:0] parsed_value;
        logic [11:0]        end_offset;
    } out_beat_t;

    // classified character handed from front to back
    typedef struct packed {
        logic       start;
        logic [5:0] base;
        logic [5:0] digit;
        logic       is_space;
        logic       is_sign;
        logic       is_minus;
        logic       is_zero;
        logic       is_x;
    } class_t;

    // value of a character as a digit, NO_DIGIT if it is none
    function automatic logic [5:0] digit_of(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'(NO_DIGIT);
            if (c >= CH_0 && c <= CH_9)
            begin
                d = c - CH_0;
            end
            else if (c >= CH_LA && c <= CH_LZ)
            begin
                d = c - CH_LA + 8'(BASE_DEC);
            end
            else if (c >= CH_UA && c <= CH_UZ)
            begin
                d = c - CH_UA + 8'(BASE_DEC);
            end
            return d[5:0];
        end
    endfunction

endpackage

// ===== design/string_to_integer_parser_top.sv =====
// a result enters the result queue as the beat that ends its number is taken
// throughput: one character per cycle unless result queue is full; 64x6 bit multiply-accumulate
// a two-beat queue parts the classifier from the parser, another holds finished results
// reset (rst_n, asynchronous): parser idle, queues empty, number_base back to 10
// top level of the string to integer parser
module string_to_integer_parser_top
    import stp_pkg::*;
#(
    parameter int unsigned MAX_LENGTH = DEF_MAX_LENGTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  in_beat_t    item,
    output logic        empty,
    input  logic        pop,
    output out_beat_t   result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [5:0]                 number_base_reg;
    logic                       cls_empty;
    logic                       cls_pop;
    class_t                     cls_head;
    logic                       res_full;
    logic                       res_push;
    out_beat_t                  res_beat;
    logic [$bits(out_beat_t)-1:0] res_bits;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_NUMBER_BASE) ? 32'(number_base_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            number_base_reg <= BASE_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_NUMBER_BASE)
        begin
            number_base_reg <= pwdata[5:0];
        end
    end

    // classifier and input queue
    stp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .item        (item),
        .number_base (number_base_reg),
        .cls_pop     (cls_pop),
        .cls_empty   (cls_empty),
        .cls_head    (cls_head)
    );

    // parser
    stp_back #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cls_empty (cls_empty),
        .cls_head  (cls_head),
        .cls_pop   (cls_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_beat  (res_beat)
    );

    // result queue
    stp_fifo #(
        .WIDTH ($bits(out_beat_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .full  (res_full),
        .wdata (res_beat),
        .pop   (pop),
        .empty (empty),
        .rdata (res_bits)
    );

    assign result = out_beat_t'(res_bits);

endmodule

// ===== design/stp_fifo.sv =====
// small register queue with push/full and pop/empty sides
module stp_fifo
    import stp_pkg::*;
#(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] rdata
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    // status and head of queue
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== design/stp_front.sv =====
// front part: classifies each character and queues it for the parser
module stp_front
    import stp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  in_beat_t   item,
    input  logic [5:0] number_base,
    input  logic       cls_pop,
    output logic       cls_empty,
    output class_t     cls_head
);

    class_t cls;
    logic [$bits(class_t)-1:0] head_bits;

    // character classification, base sampled with the beat
    always_comb
    begin
        cls.start    = item.string_start;
        cls.base     = number_base;
        cls.digit    = digit_of(item.char_code);
        cls.is_space = (item.char_code inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR});
        cls.is_sign  = (item.char_code == CH_MINUS) || (item.char_code == CH_PLUS);
        cls.is_minus = (item.char_code == CH_MINUS);
        cls.is_zero  = (item.char_code == CH_0);
        cls.is_x     = (item.char_code == CH_LX) || (item.char_code == CH_UX);
    end

    // queue between front and back
    stp_fifo #(
        .WIDTH ($bits(class_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cls_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .wdata (cls),
        .pop   (cls_pop),
        .empty (cls_empty),
        .rdata (head_bits)
    );

    assign cls_head = class_t'(head_bits);

endmodule

// ===== design/stp_back.sv =====
// back part: parser state machine with multiply-accumulate
module stp_back
    import stp_pkg::*;
#(
    parameter int unsigned MAX_LENGTH = DEF_MAX_LENGTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cls_empty,
    input  class_t    cls_head,
    output logic      cls_pop,
    input  logic      res_full,
    output logic      res_push,
    output out_beat_t res_beat
);

    localparam int unsigned CNT_W = $clog2(MAX_LENGTH + 1);
    localparam int unsigned CMP_W = (CNT_W > 12) ? CNT_W : 12;

    phase_t             phase_reg, phase_next;
    logic [5:0]         base_reg, base_next;
    logic               neg_reg, neg_next;
    logic [63:0]        acc_reg, acc_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    phase_t             cur_phase;
    logic [5:0]         cur_base;
    logic               cur_neg;
    logic [63:0]        cur_acc;
    logic [CNT_W-1:0]   cur_cnt;
    logic [CNT_W-1:0]   inc1;
    logic [CNT_W-1:0]   inc2;
    logic [5:0]         body_base;
    logic [5:0]         oct_base;
    logic [63:0]        mac;
    logic               go;
    logic               res_fire;
    logic [63:0]        res_value;
    logic [CNT_W-1:0]   res_cnt;
    logic [CMP_W-1:0]   cnt_ext;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        begin
            return (c < CNT_W'(MAX_LENGTH)) ? c + 1'b1 : c;
        end
    endfunction

    assign go      = !cls_empty && !res_full;
    assign cls_pop = go;

    // state as seen by this beat, after a possible restart
    always_comb
    begin
        cur_phase = phase_reg;
        cur_base  = base_reg;
        cur_neg   = neg_reg;
        cur_acc   = acc_reg;
        cur_cnt   = cnt_reg;
        if (cls_head.start)
        begin
            cur_phase = PH_SPACE;
            cur_base  = cls_head.base;
            cur_neg   = 1'b0;
            cur_acc   = '0;
            cur_cnt   = '0;
        end
    end

    // shared arithmetic
    assign inc1      = sat_inc(cur_cnt);
    assign inc2      = sat_inc(inc1);
    assign body_base = (cur_base == BASE_AUTO) ? BASE_DEC : cur_base;
    assign oct_base  = (cur_base == BASE_AUTO) ? BASE_OCT : cur_base;
    assign mac       = acc_reg * 64'(base_reg) + 64'(cls_head.digit);

    // next state and results
    always_comb
    begin
        phase_next = phase_reg;
        base_next  = base_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        res_fire   = 1'b0;
        res_value  = '0;
        res_cnt    = '0;
        if (go)
        begin
            phase_next = cur_phase;
            base_next  = cur_base;
            neg_next   = cur_neg;
            acc_next   = cur_acc;
            cnt_next   = cur_cnt;
            if (cls_head.start && (cls_head.base == BASE_ONE || cls_head.base > BASE_MAX))
            begin
                // unusable base: empty result, rest of string ignored
                res_fire   = 1'b1;
                phase_next = PH_IDLE;
            end
            else
            begin
                case (cur_phase)
                    PH_SPACE, PH_SIGN:
                    begin
                        if (cur_phase == PH_SPACE && cls_head.is_space)
                        begin
                            cnt_next = inc1;
                        end
                        else if (cur_phase == PH_SPACE && cls_head.is_sign)
                        begin
                            neg_next   = cls_head.is_minus;
                            cnt_next   = inc1;
                            phase_next = PH_SIGN;
                        end
                        else if ((cur_base == BASE_AUTO || cur_base == BASE_HEX)
                                 && cls_head.is_zero)
                        begin
                            acc_next   = '0;
                            cnt_next   = inc1;
                            phase_next = PH_ZERO;
                        end
                        else if (cls_head.digit < body_base)
                        begin
                            base_next  = body_base;
                            acc_next   = 64'(cls_head.digit);
                            cnt_next   = inc1;
                            phase_next = PH_DIGITS;
                        end
                        else
                        begin
                            // no digits at all
                            base_next  = body_base;
                            res_fire   = 1'b1;
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_ZERO:
                    begin
                        if (cls_head.is_x)
                        begin
                            base_next  = BASE_HEX;
                            phase_next = PH_XPFX;
                        end
                        else if (cls_head.digit < oct_base)
                        begin
                            // accumulator is zero here, so the value is the digit
                            base_next  = oct_base;
                            acc_next   = 64'(cls_head.digit);
                            cnt_next   = inc1;
                            phase_next = PH_DIGITS;
                        end
                        else
                        begin
                            base_next  = oct_base;
                            res_fire   = 1'b1;
                            res_value  = '0;
                            res_cnt    = cur_cnt;
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_XPFX:
                    begin
                        if (cls_head.digit < BASE_HEX)
                        begin
                            acc_next   = 64'(cls_head.digit);
                            cnt_next   = inc2;
                            phase_next = PH_DIGITS;
                        end
                        else
                        begin
                            // prefix without a hex digit ends just past the zero
                            res_fire   = 1'b1;
                            res_cnt    = cur_cnt;
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_DIGITS:
                    begin
                        if (cls_head.digit < cur_base)
                        begin
                            acc_next = mac;
                            cnt_next = inc1;
                        end
                        else
                        begin
                            res_fire   = 1'b1;
                            res_value  = cur_neg ? (64'd0 - cur_acc) : cur_acc;
                            res_cnt    = cur_cnt;
                            phase_next = PH_IDLE;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // result beat with saturated offset
    assign cnt_ext                = CMP_W'(res_cnt);
    assign res_push               = res_fire;
    assign res_beat.parsed_value  = res_value;
    assign res_beat.end_offset    = (cnt_ext > CMP_W'(OFF_MAX)) ? 12'(OFF_MAX) : 12'(cnt_ext);

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            base_reg  <= '0;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            base_reg  <= base_next;
            neg_reg   <= neg_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== sim/string_to_integer_parser_top_test.sv =====
// self-checking testbench of the string to integer parser top level
`timescale 1ns / 1ps

module string_to_integer_parser_top_test;
    import stp_pkg::*;

    localparam int unsigned MAX_LEN       = DEF_MAX_LENGTH;
    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          SETTLE_CYCLES = 10;
    localparam logic [7:0]  CH_NUL        = 8'h00;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        push    = 1'b0;
    logic        full;
    in_beat_t    item    = '0;
    logic        empty;
    logic        pop     = 1'b0;
    out_beat_t   result;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    // shadow of the parser: register and per-string state
    logic [5:0]  cfg_base   = BASE_RESET;
    phase_t      char_phase = PH_IDLE;
    logic        char_neg   = 1'b0;
    logic [5:0]  char_base  = '0;
    logic [63:0] char_acc   = '0;
    int unsigned char_count = 0;

    out_beat_t   number_queue[$];
    int          mismatches     = 0;
    int          cycle_count    = 0;
    int          live_chars     = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;

    string_to_integer_parser_top #(.MAX_LENGTH(MAX_LEN)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item    (item),
        .empty   (empty),
        .pop     (pop),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------------------------------------------------------- prediction

    function automatic logic [5:0] char_weight(input logic [7:0] c);
        if (c >= CH_0 && c <= CH_9)
            return 6'(c - CH_0);
        if (c >= CH_LA && c <= CH_LZ)
            return 6'(c - CH_LA + 8'd10);
        if (c >= CH_UA && c <= CH_UZ)
            return 6'(c - CH_UA + 8'd10);
        return NO_DIGIT;
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
               c == CH_FF || c == CH_CR;
    endfunction

    function automatic void bump_count();
        if (char_count < MAX_LEN)
            char_count++;
    endfunction

    function automatic void emit_number(input logic [63:0] v, input int unsigned off);
        out_beat_t r;
        r.parsed_value = v;
        r.end_offset   = (off > OFF_MAX) ? 12'(OFF_MAX) : 12'(off);
        number_queue.push_back(r);
        char_phase = PH_IDLE;
    endfunction

    function automatic void digit_step(input logic [7:0] c);
        logic [5:0] w;
        w = char_weight(c);
        if (w < char_base)
        begin
            char_acc = char_acc * 64'(char_base) + 64'(w);
            bump_count();
        end
        else
        begin
            emit_number(char_neg ? 64'd0 - char_acc : char_acc, char_count);
        end
    endfunction

    // first character after white space and sign
    function automatic void first_digit(input logic [7:0] c);
        logic [5:0] w;
        if ((char_base == BASE_AUTO || char_base == BASE_HEX) && c == CH_0)
        begin
            char_acc = '0;
            bump_count();
            char_phase = PH_ZERO;
            return;
        end
        if (char_base == BASE_AUTO)
            char_base = BASE_DEC;
        w = char_weight(c);
        if (w < char_base)
        begin
            char_acc = 64'(w);
            bump_count();
            char_phase = PH_DIGITS;
        end
        else
        begin
            emit_number('0, 0);
        end
    endfunction

    function automatic void predict_char(input in_beat_t b);
        logic [7:0] c;
        c = b.char_code;
        if (b.string_start)
        begin
            char_neg   = 1'b0;
            char_acc   = '0;
            char_count = 0;
            char_base  = cfg_base;
            // invalid base answers on the start beat
            if (char_base == BASE_ONE || char_base > BASE_MAX)
            begin
                emit_number('0, 0);
                return;
            end
            char_phase = PH_SPACE;
        end
        case (char_phase)
            PH_SPACE:
            begin
                if (is_blank(c))
                    bump_count();
                else if (c == CH_MINUS || c == CH_PLUS)
                begin
                    char_neg = (c == CH_MINUS);
                    bump_count();
                    char_phase = PH_SIGN;
                end
                else
                    first_digit(c);
            end
            PH_SIGN:
                first_digit(c);
            PH_ZERO:
            begin
                if (c == CH_LX || c == CH_UX)
                begin
                    char_base  = BASE_HEX;
                    char_phase = PH_XPFX;
                end
                else
                begin
                    if (char_base == BASE_AUTO)
                        char_base = BASE_OCT;
                    char_phase = PH_DIGITS;
                    digit_step(c);
                end
            end
            PH_XPFX:
            begin
                if (char_weight(c) < BASE_HEX)
                begin
                    char_acc = 64'(char_weight(c));
                    bump_count();
                    bump_count();
                    char_phase = PH_DIGITS;
                end
                else
                    emit_number('0, char_count);
            end
            PH_DIGITS:
                digit_step(c);
            default:
                ;
        endcase
    endfunction

    // ---------------------------------------------------------------- result side

    // result checker and random pop
    always @(posedge clk)
    begin
        out_beat_t want;
        if (rst_n && pop && empty === 1'b0)
        begin
            if (number_queue.size() == 0)
            begin
                $display("%0t: unexpected result beat, value %0d offset %0d",
                         $realtime, result.parsed_value, result.end_offset);
                mismatches++;
            end
            else
            begin
                want = number_queue.pop_front();
                if (result.parsed_value !== want.parsed_value)
                begin
                    $display("%0t: parsed_value expected %0d actual %0d",
                             $realtime, want.parsed_value, result.parsed_value);
                    mismatches++;
                end
                if (result.end_offset !== want.end_offset)
                begin
                    $display("%0t: end_offset expected %0d actual %0d",
                             $realtime, want.end_offset, result.end_offset);
                    mismatches++;
                end
            end
        end
        pop <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ---------------------------------------------------------------- input side

    task automatic send_char(input logic [7:0] c, input logic st);
        in_beat_t b;
        begin
            b.char_code    = c;
            b.string_start = st;
            push <= 1'b1;
            item <= b;
            @(posedge clk);
            while (full !== 1'b0)
                @(posedge clk);
            if (st || char_phase != PH_IDLE)
                live_chars++;
            predict_char(b);
            // sender gap
            while ($urandom_range(99) < send_idle_pct)
            begin
                push <= 1'b0;
                @(posedge clk);
            end
        end
    endtask

    task automatic send_text(input string txt, input bit add_nul);
        int k;
        begin
            for (k = 0; k < txt.len(); k++)
                send_char(txt[k], k == 0);
            if (add_nul)
                send_char(CH_NUL, txt.len() == 0);
        end
    endtask

    // wait until every expected number is out and the pipeline is quiet
    task automatic drain_results();
        begin
            push <= 1'b0;
            while (number_queue.size() != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    task automatic write_base(input logic [5:0] b);
        begin
            drain_results();
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {REG_NUMBER_BASE, 2'b00};
            pwdata  <= 32'(b);
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            while (pready !== 1'b1)
                @(posedge clk);
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            cfg_base = b;
        end
    endtask

    function automatic logic [7:0] blank_char();
        case ($urandom_range(5))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_LF;
            3: return CH_VT;
            4: return CH_FF;
            default: return CH_CR;
        endcase
    endfunction

    function automatic logic [7:0] digit_char(input int v);
        if (v < 10)
            return CH_0 + 8'(v);
        return ($urandom_range(1) ? CH_LA : CH_UA) + 8'(v - 10);
    endfunction

    // one string: mostly well formed with random content, some noise
    task automatic send_random_string();
        logic [7:0] s[$];
        int eff;
        int n;
        int k;
        int r;
        begin
            // noise beats with random start flags
            if ($urandom_range(99) < 10)
            begin
                repeat ($urandom_range(1, 12))
                    send_char(8'($urandom), $urandom_range(3) == 0);
                return;
            end
            eff = cfg_base;
            repeat ($urandom_range(3)) s.push_back(blank_char());
            if ($urandom_range(1))
                s.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);
            r = $urandom_range(99);
            if ((eff == BASE_AUTO || eff == BASE_HEX) && r < 30)
            begin
                s.push_back(CH_0);
                s.push_back($urandom_range(1) ? CH_LX : CH_UX);
                eff = BASE_HEX;
            end
            else if (r < 45)
            begin
                s.push_back(CH_0);
                if (eff == BASE_AUTO)
                    eff = BASE_OCT;
            end
            if (eff == BASE_AUTO)
                eff = BASE_DEC;
            if (eff == BASE_ONE || eff > BASE_MAX)
                eff = BASE_MAX;
            // mostly short numbers, now and then long enough to wrap
            n = ($urandom_range(9) == 0) ? $urandom_range(15, 30) : $urandom_range(6);
            repeat (n)
                s.push_back(($urandom_range(19) == 0) ? 8'($urandom)
                                                        : digit_char($urandom_range(eff - 1)));
            // terminator, stray character, or cut short for a restart
            r = $urandom_range(9);
            if (r >= 1 && r <= 5)
                s.push_back(CH_NUL);
            else if (r > 5)
                s.push_back(8'($urandom));
            if (s.size() == 0)
                s.push_back(8'($urandom));
            for (k = 0; k < s.size(); k++)
                send_char(s[k], k == 0);
            // trailing characters, ignored once the number has ended
            repeat ($urandom_range(2))
                send_char(8'($urandom), 1'b0);
        end
    endtask

    task automatic run_phase(input logic [5:0] b, input idle_mode_t mode, input int count);
        int first;
        begin
            write_base(b);
            case (mode)
                IDLE_SEND:
                begin
                    send_idle_pct  = 67;
                    recv_stall_pct = 0;
                end
                IDLE_RECV:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 67;
                end
                IDLE_BOTH:
                begin
                    send_idle_pct  = 18;
                    recv_stall_pct = 18;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            first = live_chars;
            while (live_chars - first < count)
                send_random_string();
        end
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_directed_cases();
        begin
            // reset base of ten, sign and terminator
            send_text("-9", 1);
            // no digits at all
            send_text("", 1);
            send_text("+x", 0);
            // restart mid-string, then a character while idle
            send_text("5", 0);
            send_text("\t7", 1);
            send_char(8'hff, 1'b0);
            // detected base: hex, prefix without hex digit, octal stopped by eight
            write_base(BASE_AUTO);
            send_text("0xF", 1);
            send_text("0Xg", 0);
            send_text("08", 0);
            // invalid bases answer on the start beat
            write_base(BASE_ONE);
            send_text("5", 0);
            write_base(6'd63);
            send_text("1", 0);
            // highest base, both letter cases
            write_base(BASE_MAX);
            send_text("Zz ", 0);
        end
    endtask

    task automatic test_limits();
        int k;
        begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
            write_base(BASE_DEC);
            // offset saturation with a wrapping negative value
            for (k = 0; k < 4090; k++)
                send_char(blank_char(), k == 0);
            send_char(CH_MINUS, 1'b0);
            repeat (30) send_char(digit_char($urandom_range(9)), 1'b0);
            send_char(CH_NUL, 1'b0);
            // most negative value and unsigned wrap to minus one
            send_text("-9223372036854775808", 1);
            send_text("18446744073709551615", 1);
            send_text("9223372036854775807", 1);
        end
    endtask

    task automatic test_random_traffic();
        int k;
        begin
            run_phase(BASE_DEC, IDLE_NONE, 200);
            run_phase(BASE_AUTO, IDLE_SEND, 200);
            run_phase(BASE_HEX, IDLE_RECV, 200);
            run_phase(BASE_MAX, IDLE_BOTH, 150);
            run_phase(6'd2, IDLE_NONE, 100);
            run_phase(BASE_OCT, IDLE_SEND, 100);
            // random settings, now and then an invalid one
            for (k = 0; k < 6; k++)
                run_phase(($urandom_range(3) == 0) ? 6'($urandom_range(63))
                                                   : 6'($urandom_range(36)),
                          idle_mode_t'(k % 4), 60);
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_limits();
        test_random_traffic();
        drain_results();
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/stp_pkg.sv
design/stp_fifo.sv
design/stp_front.sv
design/stp_back.sv
design/string_to_integer_parser_top.sv
sim/string_to_integer_parser_top_test.sv
